// ===== rtl/edo_pkg.sv =====
// Shared types and constants for the EDO note-to-frequency converter.
// Holds field widths, polynomial coefficients, reset values and register indexes.
// Depends on nothing; every other file of the block but edo_chan_if.sv refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package edo_pkg;

    // Field widths of the ports.
    localparam int NOTE_W     = 9;
    localparam int REF_NOTE_W = 7;
    localparam int STEPS_W    = 8;
    localparam int REF_FREQ_W = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int FREQ_OUT_W = 40;

    // Internal widths. The difference note - ref_note lies in [-383, 255].
    localparam int DIFF_W = 10;
    localparam int MAG_W  = 9;
    // The octave count lies in [-383, 255].
    localparam int OCT_W  = 10;

    // Mantissa polynomial, Q0.30 coefficients and a Q1.30 result.
    localparam int COEF_W    = 30;
    localparam int MANT_W    = 31;
    localparam int MANT_FRAC = 30;
    localparam logic [COEF_W-1:0] POLY_C1 = 30'd746442338;
    localparam logic [COEF_W-1:0] POLY_C2 = 30'd242853664;
    localparam logic [COEF_W-1:0] POLY_C3 = 30'd83776880;
    localparam logic [MANT_W-1:0] Q30_ONE = 31'd1073741824;

    // Scaling and final shift.
    localparam int PROD_W     = MANT_W + REF_FREQ_W;
    localparam int WIDE_W     = PROD_W + FREQ_OUT_W;
    localparam int SHIFT_W    = 6;
    localparam int LSHIFT_MAX = 40;
    localparam int RSHIFT_MAX = 63;
    localparam logic [FREQ_OUT_W-1:0] FREQ_MAX = {FREQ_OUT_W{1'b1}};

    // Register reset values.
    localparam logic [REF_FREQ_W-1:0] REF_FREQ_RST = 32'd28835840;
    localparam logic [REF_NOTE_W-1:0] REF_NOTE_RST = 7'd69;
    localparam logic [STEPS_W-1:0]    STEPS_RST    = 8'd12;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REF_FREQ = 2'd0,
        REG_REF_NOTE = 2'd1,
        REG_STEPS    = 2'd2
    } cfg_reg_t;

    // Channel payloads.
    typedef logic signed [NOTE_W-1:0] note_t;

    typedef struct packed {
        logic [FREQ_OUT_W-1:0] frequency;
        logic                  overflow;
    } freq_t;

endpackage

`default_nettype wire

// ===== rtl/edo_chan_if.sv =====
// Valid/ready channel used for the note requests and the frequency results.
// The payload type is a parameter; the block uses edo_pkg::note_t and edo_pkg::freq_t.
`timescale 1ns / 1ps
`default_nettype none

interface edo_chan_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ===== rtl/edo_div.sv =====
// Pipelined floor division of note - ref_note by the step count, one quotient bit per stage.
// Produces the octave count and a FRAC_BITS fraction of the remainder. Uses edo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module edo_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    en,
    input  wire logic                                    in_valid,
    input  wire edo_pkg::note_t                          note,
    input  wire logic [edo_pkg::REF_NOTE_W-1:0]          ref_note,
    input  wire logic [edo_pkg::STEPS_W-1:0]             divisor,
    output logic                                         out_valid,
    output logic signed [edo_pkg::OCT_W-1:0]             octave,
    output logic [FRAC_BITS-1:0]                         frac
);

    localparam int MAG_W   = edo_pkg::MAG_W;
    localparam int STEPS_W = edo_pkg::STEPS_W;
    localparam int OCT_W   = edo_pkg::OCT_W;
    localparam int DIFF_W  = edo_pkg::DIFF_W;

    // Integer quotient stages; stage 0 holds the magnitude of the difference.
    logic               iv_reg   [MAG_W+1];
    logic               ineg_reg [MAG_W+1];
    logic [MAG_W-1:0]   imag_reg [MAG_W+1];
    logic [STEPS_W-1:0] irem_reg [MAG_W+1];
    logic [MAG_W-1:0]   iquo_reg [MAG_W+1];

    // Fraction stages; stage 0 holds the floor-corrected octave and remainder.
    logic                    fv_reg   [FRAC_BITS+1];
    logic signed [OCT_W-1:0] foct_reg [FRAC_BITS+1];
    logic [STEPS_W-1:0]      frem_reg [FRAC_BITS+1];
    logic [FRAC_BITS-1:0]    fq_reg   [FRAC_BITS+1];

    logic signed [DIFF_W-1:0] diff_next;
    logic [MAG_W-1:0]         mag_next;

    // Signed difference and its magnitude.
    assign diff_next = DIFF_W'(note) - DIFF_W'(signed'({1'b0, ref_note}));
    assign mag_next  = MAG_W'(diff_next[DIFF_W-1] ? -diff_next : diff_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            iv_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ineg_reg[0] <= diff_next[DIFF_W-1];
            imag_reg[0] <= mag_next;
            irem_reg[0] <= '0;
            iquo_reg[0] <= '0;
        end
    end

    // One restoring step per stage on the magnitude, most significant bit first.
    for (genvar k = 1; k <= MAG_W; k++)
    begin : g_int
        logic [STEPS_W:0]   trial;
        logic               ge;
        logic [STEPS_W-1:0] rem_next;

        assign trial    = {irem_reg[k-1], imag_reg[k-1][MAG_W-k]};
        assign ge       = (trial >= {1'b0, divisor});
        assign rem_next = ge ? STEPS_W'(trial - {1'b0, divisor}) : STEPS_W'(trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                iv_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                iv_reg[k] <= iv_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ineg_reg[k] <= ineg_reg[k-1];
                imag_reg[k] <= imag_reg[k-1];
                irem_reg[k] <= rem_next;
                iquo_reg[k] <= {iquo_reg[k-1][MAG_W-2:0], ge};
            end
        end
    end

    // Floor correction: a negative difference with a nonzero remainder drops one more octave.
    logic                    rem_nz;
    logic signed [OCT_W-1:0] quo_ext;
    logic signed [OCT_W-1:0] oct_next;
    logic [STEPS_W-1:0]      fix_rem_next;

    assign rem_nz       = |irem_reg[MAG_W];
    assign quo_ext      = signed'(OCT_W'(iquo_reg[MAG_W]));
    assign oct_next     = ineg_reg[MAG_W] ? (-quo_ext - signed'(OCT_W'(rem_nz))) : quo_ext;
    assign fix_rem_next = (ineg_reg[MAG_W] && rem_nz) ? (divisor - irem_reg[MAG_W])
                                                      : irem_reg[MAG_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            fv_reg[0] <= iv_reg[MAG_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            foct_reg[0] <= oct_next;
            frem_reg[0] <= fix_rem_next;
            fq_reg[0]   <= '0;
        end
    end

    // Fraction bits of remainder / divisor, one bit per stage.
    for (genvar k = 1; k <= FRAC_BITS; k++)
    begin : g_frac
        logic [STEPS_W:0]   trial;
        logic               ge;
        logic [STEPS_W-1:0] rem_next;

        assign trial    = {frem_reg[k-1], 1'b0};
        assign ge       = (trial >= {1'b0, divisor});
        assign rem_next = ge ? STEPS_W'(trial - {1'b0, divisor}) : STEPS_W'(trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                fv_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                fv_reg[k] <= fv_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                foct_reg[k] <= foct_reg[k-1];
                frem_reg[k] <= rem_next;
                fq_reg[k]   <= {fq_reg[k-1][FRAC_BITS-2:0], ge};
            end
        end
    end

    assign out_valid = fv_reg[FRAC_BITS];
    assign octave    = foct_reg[FRAC_BITS];
    assign frac      = fq_reg[FRAC_BITS];

endmodule

`default_nettype wire

// ===== rtl/edo_exp2.sv =====
// Three-stage cubic approximation of 2^f for a FRAC_BITS fraction, one multiply per stage.
// Produces a Q1.30 mantissa and carries the octave count along. Uses edo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module edo_exp2 #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire logic                                in_valid,
    input  wire logic signed [edo_pkg::OCT_W-1:0]    in_octave,
    input  wire logic [FRAC_BITS-1:0]                frac,
    output logic                                     out_valid,
    output logic signed [edo_pkg::OCT_W-1:0]         out_octave,
    output logic [edo_pkg::MANT_W-1:0]               mant
);

    localparam int COEF_W = edo_pkg::COEF_W;
    localparam int MANT_W = edo_pkg::MANT_W;
    localparam int OCT_W  = edo_pkg::OCT_W;
    localparam int PW     = COEF_W + FRAC_BITS;

    logic                    v1_reg, v2_reg, v3_reg;
    logic signed [OCT_W-1:0] oct1_reg, oct2_reg, oct3_reg;
    logic [FRAC_BITS-1:0]    f1_reg, f2_reg;
    logic [COEF_W-1:0]       a2_reg, a1_reg;
    logic [MANT_W-1:0]       m_reg;

    logic [PW-1:0]     prod1, prod2, prod3;
    logic [COEF_W-1:0] a2_next, a1_next;
    logic [MANT_W-1:0] m_next;

    // Horner steps: C3*f + C2, then a*f + C1, then a*f + 1.
    assign prod1   = PW'(edo_pkg::POLY_C3) * PW'(frac);
    assign a2_next = edo_pkg::POLY_C2 + COEF_W'(prod1 >> FRAC_BITS);
    assign prod2   = PW'(a2_reg) * PW'(f1_reg);
    assign a1_next = edo_pkg::POLY_C1 + COEF_W'(prod2 >> FRAC_BITS);
    assign prod3   = PW'(a1_reg) * PW'(f2_reg);
    assign m_next  = edo_pkg::Q30_ONE + MANT_W'(prod3 >> FRAC_BITS);

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Data stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a2_reg   <= a2_next;
            f1_reg   <= frac;
            oct1_reg <= in_octave;
            a1_reg   <= a1_next;
            f2_reg   <= f1_reg;
            oct2_reg <= oct1_reg;
            m_reg    <= m_next;
            oct3_reg <= oct2_reg;
        end
    end

    assign out_valid  = v3_reg;
    assign out_octave = oct3_reg;
    assign mant       = m_reg;

endmodule

`default_nettype wire

// ===== rtl/edo_scale.sv =====
// Scales the reference frequency by the mantissa and shifts by the octave count.
// Two stages: multiply, then shift with saturation into Q24.16. Uses edo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module edo_scale (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire logic                                in_valid,
    input  wire logic signed [edo_pkg::OCT_W-1:0]    octave,
    input  wire logic [edo_pkg::MANT_W-1:0]          mant,
    input  wire logic [edo_pkg::REF_FREQ_W-1:0]      ref_freq,
    output logic                                     out_valid,
    output edo_pkg::freq_t                           result
);

    localparam int OCT_W   = edo_pkg::OCT_W;
    localparam int PROD_W  = edo_pkg::PROD_W;
    localparam int WIDE_W  = edo_pkg::WIDE_W;
    localparam int SHIFT_W = edo_pkg::SHIFT_W;
    localparam int OUT_W   = edo_pkg::FREQ_OUT_W;
    localparam int SH_W    = OCT_W + 1;

    logic                v1_reg, v2_reg;
    logic [PROD_W-1:0]   p_reg;
    logic                left_reg;
    logic [SHIFT_W-1:0]  amt_reg;
    edo_pkg::freq_t      res_reg;

    logic [PROD_W-1:0]      p_next;
    logic signed [SH_W-1:0] s_next;
    logic signed [SH_W-1:0] r_next;
    logic [SHIFT_W-1:0]     amt_next;
    logic [WIDE_W-1:0]      wide;
    logic [WIDE_W-1:0]      shifted;
    logic                   ovf_next;
    edo_pkg::freq_t         res_next;

    // Product and clamped shift amount: left by octave - 30, else right by 30 - octave.
    assign p_next = PROD_W'(mant) * PROD_W'(ref_freq);
    assign s_next = SH_W'(octave) - SH_W'(edo_pkg::MANT_FRAC);
    assign r_next = -s_next;

    always_comb
    begin
        if (!s_next[SH_W-1])
        begin
            amt_next = (s_next >= SH_W'(edo_pkg::LSHIFT_MAX))
                       ? SHIFT_W'(edo_pkg::LSHIFT_MAX) : SHIFT_W'(s_next);
        end
        else
        begin
            amt_next = (r_next >= SH_W'(edo_pkg::RSHIFT_MAX))
                       ? SHIFT_W'(edo_pkg::RSHIFT_MAX) : SHIFT_W'(r_next);
        end
    end

    // Shift and saturate; any bit above the output width means overflow.
    assign wide     = WIDE_W'(p_reg);
    assign shifted  = left_reg ? (wide << amt_reg) : (wide >> amt_reg);
    assign ovf_next = |shifted[WIDE_W-1:OUT_W];

    always_comb
    begin
        res_next.overflow  = ovf_next;
        res_next.frequency = ovf_next ? edo_pkg::FREQ_MAX : shifted[OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg    <= p_next;
            left_reg <= !s_next[SH_W-1];
            amt_reg  <= amt_next;
            res_reg  <= res_next;
        end
    end

    assign out_valid = v2_reg;
    assign result    = res_reg;

endmodule

`default_nettype wire

// ===== rtl/edo_note_to_frequency.sv =====
// Converts note numbers to frequencies ref_freq * 2^((note - ref_note) / steps) in Q24.16.
// Top level: configuration registers, the divider, exp2 and scaling pipelines, output skid.
// Uses edo_pkg, edo_chan_if, edo_div, edo_exp2 and edo_scale.
//
// A note request is accepted every clock cycle while the skid register is empty, and each
// one produces exactly one result. From acceptance to a valid result the request passes
// through these steps in order: the note difference is formed, the whole octave count is
// produced one quotient bit at a time, the floor correction is applied, the fraction is
// produced one bit at a time, the exp2 polynomial is evaluated, and the value is multiplied
// by the reference and shifted. When the result side stalls, one result parks in a skid
// register and the note side then stalls too.
// Write the configuration only while no requests are in flight.
`timescale 1ns / 1ps
`default_nettype none

module edo_note_to_frequency #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [edo_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [edo_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    edo_chan_if.sink                                  note_chan,
    edo_chan_if.source                                freq_chan
);

    // Configuration registers.
    logic [edo_pkg::REF_FREQ_W-1:0] ref_freq_reg;
    logic [edo_pkg::REF_NOTE_W-1:0] ref_note_reg;
    logic [edo_pkg::STEPS_W-1:0]    steps_reg;
    logic [edo_pkg::STEPS_W-1:0]    divisor;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_freq_reg <= edo_pkg::REF_FREQ_RST;
            ref_note_reg <= edo_pkg::REF_NOTE_RST;
            steps_reg    <= edo_pkg::STEPS_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                edo_pkg::REG_REF_FREQ: ref_freq_reg <= cfg_wdata[edo_pkg::REF_FREQ_W-1:0];
                edo_pkg::REG_REF_NOTE: ref_note_reg <= cfg_wdata[edo_pkg::REF_NOTE_W-1:0];
                edo_pkg::REG_STEPS:    steps_reg    <= cfg_wdata[edo_pkg::STEPS_W-1:0];
                default:               ;
            endcase
        end
    end

    // A step count of zero divides like one.
    assign divisor = (steps_reg == '0) ? edo_pkg::STEPS_W'(1) : steps_reg;

    // The whole pipeline advances together while the skid register is empty.
    logic skid_valid_reg;
    logic skid_valid_next;
    logic en;

    assign en              = !skid_valid_reg;
    assign note_chan.ready = en;

    logic                                div_valid;
    logic signed [edo_pkg::OCT_W-1:0]    div_octave;
    logic [FRAC_BITS-1:0]                div_frac;
    logic                                exp_valid;
    logic signed [edo_pkg::OCT_W-1:0]    exp_octave;
    logic [edo_pkg::MANT_W-1:0]          exp_mant;
    logic                                last_valid;
    edo_pkg::freq_t                      last_res;

    edo_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (note_chan.valid),
        .note      (note_chan.data),
        .ref_note  (ref_note_reg),
        .divisor   (divisor),
        .out_valid (div_valid),
        .octave    (div_octave),
        .frac      (div_frac)
    );

    edo_exp2 #(
        .FRAC_BITS (FRAC_BITS)
    ) u_exp2 (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (div_valid),
        .in_octave  (div_octave),
        .frac       (div_frac),
        .out_valid  (exp_valid),
        .out_octave (exp_octave),
        .mant       (exp_mant)
    );

    edo_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (exp_valid),
        .octave    (exp_octave),
        .mant      (exp_mant),
        .ref_freq  (ref_freq_reg),
        .out_valid (last_valid),
        .result    (last_res)
    );

    // Output skid: catches the last-stage result when the consumer is not ready.
    edo_pkg::freq_t skid_reg;

    always_comb
    begin
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (freq_chan.ready)
            begin
                skid_valid_next = 1'b0;
            end
        end
        else if (last_valid && !freq_chan.ready)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            skid_reg <= last_res;
        end
    end

    assign freq_chan.valid = skid_valid_reg || last_valid;
    assign freq_chan.data  = skid_valid_reg ? skid_reg : last_res;

    // A saturated result always carries the full-scale frequency.
    assert property (@(posedge clk) disable iff (!rst_n)
        freq_chan.valid && freq_chan.data.overflow
        |-> freq_chan.data.frequency == edo_pkg::FREQ_MAX)
        else $error("Overflow flagged without a saturated frequency.");

    // A parked result stays parked and unchanged until the consumer takes it.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !freq_chan.ready |=> skid_valid_reg && $stable(skid_reg))
        else $error("Skid register changed while its result was waiting.");

    // The skid register fills only from a valid last stage that the consumer refused.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(last_valid && !freq_chan.ready))
        else $error("Skid register filled without a stalled result.");

    // A taken parked result frees the skid register on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && freq_chan.ready |=> !skid_valid_reg)
        else $error("Skid register did not drain after its result was taken.");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the EDO note-to-frequency converter.
// Drives note requests and configuration writes and checks every frequency against a predictor.
// Depends on rtl/edo_pkg.sv, rtl/edo_chan_if.sv and the edo_note_to_frequency RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int FRAC_BITS       = 16;
    localparam int PIPE_LATENCY    = FRAC_BITS + 16;
    localparam int QUIET_LIMIT     = 3000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_PHASES   = 12;
    localparam int NOTES_PER_PHASE = 158;
    localparam logic [edo_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef bit [63:0] u64_t;

    typedef struct {
        edo_pkg::note_t note;
        edo_pkg::freq_t pitch;
    } pitch_entry_t;

    // Scoreboard: mirrors the registers, predicts each pitch and checks results in order.
    class pitch_ledger;
        logic [edo_pkg::REF_FREQ_W-1:0] ref_freq;
        logic [edo_pkg::REF_NOTE_W-1:0] ref_note;
        logic [edo_pkg::STEPS_W-1:0]    steps;
        pitch_entry_t                   pending_pitches [$];
        int unsigned                    mismatches;

        function new();
            ref_freq   = edo_pkg::REF_FREQ_RST;
            ref_note   = edo_pkg::REF_NOTE_RST;
            steps      = edo_pkg::STEPS_RST;
            mismatches = 0;
        endfunction

        // Writes to an unknown index leave the registers untouched.
        function void set_register(logic [edo_pkg::CFG_IDX_W-1:0] idx,
                                   logic [edo_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                edo_pkg::REG_REF_FREQ: ref_freq = val[edo_pkg::REF_FREQ_W-1:0];
                edo_pkg::REG_REF_NOTE: ref_note = val[edo_pkg::REF_NOTE_W-1:0];
                edo_pkg::REG_STEPS:    steps    = val[edo_pkg::STEPS_W-1:0];
                default: ;
            endcase
        endfunction

        // Floor-divide the note distance into octaves and a fraction, approximate 2^f,
        // scale the reference and shift by the octave count with saturation.
        function edo_pkg::freq_t pitch_of(edo_pkg::note_t n);
            int             divisor;
            int             diff;
            int             octave;
            int             remnant;
            int             shift;
            u64_t           frac;
            u64_t           acc;
            u64_t           mant;
            u64_t           prod;
            u64_t           q;
            u64_t           limit;
            edo_pkg::freq_t res;
            limit   = {24'b0, edo_pkg::FREQ_MAX};
            divisor = (steps == 0) ? 1 : int'(steps);
            diff    = int'(n) - int'(ref_note);
            octave  = diff / divisor;
            remnant = diff % divisor;
            if (remnant < 0)
            begin
                remnant = remnant + divisor;
                octave  = octave - 1;
            end
            frac = (u64_t'(remnant) << FRAC_BITS) / u64_t'(divisor);
            acc  = u64_t'(edo_pkg::POLY_C3);
            acc  = u64_t'(edo_pkg::POLY_C2) + ((acc * frac) >> FRAC_BITS);
            acc  = u64_t'(edo_pkg::POLY_C1) + ((acc * frac) >> FRAC_BITS);
            mant = u64_t'(edo_pkg::Q30_ONE) + ((acc * frac) >> FRAC_BITS);
            prod = mant * u64_t'(ref_freq);
            shift = octave - edo_pkg::MANT_FRAC;
            res.frequency = '0;
            res.overflow  = 1'b0;
            if (prod == 0)
            begin
                res.frequency = '0;
            end
            else if (shift >= 0)
            begin
                if (shift >= edo_pkg::LSHIFT_MAX || prod > (limit >> shift))
                begin
                    res.frequency = edo_pkg::FREQ_MAX;
                    res.overflow  = 1'b1;
                end
                else
                begin
                    q = prod << shift;
                    res.frequency = q[edo_pkg::FREQ_OUT_W-1:0];
                end
            end
            else
            begin
                q = (-shift >= 64) ? 64'd0 : (prod >> (-shift));
                if (q > limit)
                begin
                    res.frequency = edo_pkg::FREQ_MAX;
                    res.overflow  = 1'b1;
                end
                else
                begin
                    res.frequency = q[edo_pkg::FREQ_OUT_W-1:0];
                end
            end
            return res;
        endfunction

        function void log_note(edo_pkg::note_t n);
            pitch_entry_t entry;
            entry.note  = n;
            entry.pitch = pitch_of(n);
            pending_pitches.push_back(entry);
        endfunction

        function void check_pitch(edo_pkg::freq_t got);
            pitch_entry_t want;
            if (pending_pitches.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, got frequency %h overflow %b",
                         $time, got.frequency, got.overflow);
                mismatches++;
                return;
            end
            want = pending_pitches.pop_front();
            if (got.frequency !== want.pitch.frequency)
            begin
                $display("%0t: note %0d frequency: expected %h, got %h",
                         $time, want.note, want.pitch.frequency, got.frequency);
                mismatches++;
            end
            if (got.overflow !== want.pitch.overflow)
            begin
                $display("%0t: note %0d overflow: expected %b, got %b",
                         $time, want.note, want.pitch.overflow, got.overflow);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_pitches.size();
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic [edo_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [edo_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    edo_chan_if #(.payload_t(edo_pkg::note_t)) note_chan ();
    edo_chan_if #(.payload_t(edo_pkg::freq_t)) freq_chan ();

    pitch_ledger ledger = new();

    int quiet_cycles = 0;
    int burst_left   = 0;
    bit sender_busy  = 1'b0;
    bit squeeze_go   = 1'b0;
    bit took_any;

    edo_note_to_frequency #(
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .note_chan (note_chan),
        .freq_chan (freq_chan)
    );

    always #5 clk = ~clk;

    // Log accepted requests, check accepted results, and watch for a stalled run.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            took_any = 1'b0;
            if (note_chan.valid === 1'b1 && note_chan.ready === 1'b1)
            begin
                ledger.log_note(note_chan.data);
                took_any = 1'b1;
            end
            if (freq_chan.valid === 1'b1 && freq_chan.ready === 1'b1)
            begin
                ledger.check_pitch(freq_chan.data);
                took_any = 1'b1;
            end
            quiet_cycles = took_any ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Result side: segments of steady, random and periodic stalls, plus one long hold-off.
    initial
    begin : receiver
        int  mode;
        int  len;
        bit  squeeze_done;
        squeeze_done = 1'b0;
        freq_chan.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (squeeze_go && !squeeze_done)
            begin
                freq_chan.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                squeeze_done = 1'b1;
            end
            mode = $urandom_range(0, 3);
            len  = $urandom_range(5, 60);
            for (int k = 0; k < len; k++)
            begin
                case (mode)
                    0:       freq_chan.ready <= 1'b1;
                    1:       freq_chan.ready <= ($urandom_range(0, 3) != 0);
                    2:       freq_chan.ready <= 1'($urandom_range(0, 1));
                    default: freq_chan.ready <= (k % 4 != 3);
                endcase
                @(posedge clk);
            end
        end
    end

    // Offer one note request, inserting a gap at the end of each burst.
    task automatic send_note(input edo_pkg::note_t n);
        if (burst_left == 0)
        begin
            if (sender_busy)
            begin
                note_chan.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                      : $urandom_range(1, 30);
        end
        burst_left--;
        note_chan.valid <= 1'b1;
        note_chan.data  <= n;
        sender_busy = 1'b1;
        @(posedge clk);
        while (note_chan.ready !== 1'b1) @(posedge clk);
    endtask

    // Stop offering, wait for every pending pitch, then let the pipeline empty.
    task automatic settle_pipeline();
        if (sender_busy)
            note_chan.valid <= 1'b0;
        sender_busy = 1'b0;
        burst_left  = 0;
        @(posedge clk);
        while (ledger.outstanding() != 0) @(posedge clk);
        repeat (PIPE_LATENCY + 8) @(posedge clk);
    endtask

    // Write all three registers back to back, optionally followed by an unknown index.
    task automatic program_regs(input logic [edo_pkg::REF_FREQ_W-1:0] freq_q16,
                                input logic [edo_pkg::REF_NOTE_W-1:0] base_note,
                                input logic [edo_pkg::STEPS_W-1:0]    divisions,
                                input bit                             poke_unused);
        logic [edo_pkg::CFG_IDX_W-1:0]  idx_list [4];
        logic [edo_pkg::CFG_DATA_W-1:0] val_list [4];
        int                             writes;
        idx_list[0] = edo_pkg::REG_REF_FREQ;
        val_list[0] = freq_q16;
        idx_list[1] = edo_pkg::REG_REF_NOTE;
        val_list[1] = {25'b0, base_note};
        idx_list[2] = edo_pkg::REG_STEPS;
        val_list[2] = {24'b0, divisions};
        idx_list[3] = REG_UNUSED;
        val_list[3] = $urandom;
        writes = poke_unused ? 4 : 3;
        for (int w = 0; w < writes; w++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx_list[w];
            cfg_wdata <= val_list[w];
            @(posedge clk);
            ledger.set_register(idx_list[w], val_list[w]);
        end
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [edo_pkg::REF_FREQ_W-1:0] rf;
        logic [edo_pkg::REF_NOTE_W-1:0] rn;
        logic [edo_pkg::STEPS_W-1:0]    sp;
        int                             span;
        int                             target;
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_wdata       = '0;
        note_chan.valid = 1'b0;
        note_chan.data  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: 440 Hz at note 69 with twelve steps, field extremes included.
        send_note(-256);
        send_note(255);
        send_note(0);
        send_note(69);
        send_note(57);
        send_note(70);
        settle_pipeline();

        // Zero divisions act as one; large notes saturate and low notes flush to zero.
        program_regs(edo_pkg::REF_FREQ_RST, 7'd0, 8'd0, 1'b1);
        send_note(0);
        send_note(9);
        send_note(40);
        send_note(255);
        send_note(-30);
        send_note(-256);
        settle_pipeline();

        // A zero reference gives zero whatever the note.
        program_regs(32'd0, 7'd64, 8'd7, 1'b0);
        send_note(255);
        send_note(-256);
        send_note(3);
        settle_pipeline();

        // Largest reference, highest reference note and most divisions.
        program_regs(32'hFFFF_FFFF, 7'd127, 8'd255, 1'b0);
        send_note(255);
        send_note(-256);
        send_note(126);
        send_note(127);
        settle_pipeline();

        // Smallest reference: values below one LSB and shifts around the mantissa point.
        program_regs(32'd1, 7'd64, 8'd1, 1'b0);
        send_note(64);
        send_note(94);
        send_note(33);
        send_note(103);
        settle_pipeline();

        // Random phases, each with its own settings; the second one carries the hold-off.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case ($urandom_range(0, 5))
                0:       rf = edo_pkg::REF_FREQ_RST;
                1:       rf = 32'd0;
                2:       rf = 32'hFFFF_FFFF;
                3:       rf = 32'd1;
                default: rf = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0:       rn = 7'd0;
                1:       rn = 7'd127;
                default: rn = 7'($urandom_range(0, 127));
            endcase
            case ($urandom_range(0, 5))
                0:       sp = 8'd0;
                1:       sp = 8'd255;
                2:       sp = 8'd1;
                default: sp = 8'($urandom_range(2, 24));
            endcase
            program_regs(rf, rn, sp, ($urandom_range(0, 3) == 0));
            if (ph == 1)
                squeeze_go = 1'b1;
            span = (sp == 0) ? 1 : int'(sp);
            for (int i = 0; i < NOTES_PER_PHASE; i++)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    send_note(edo_pkg::note_t'($urandom_range(0, 511)));
                end
                else
                begin
                    // Notes within a few octaves of the reference keep results in range.
                    target = int'(rn) + int'($urandom_range(0, 6 * span)) - 3 * span;
                    if (target > 255)
                        target = 255;
                    if (target < -256)
                        target = -256;
                    send_note(edo_pkg::note_t'(target));
                end
            end
            settle_pipeline();
        end

        if (ledger.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/edo_pkg.sv
rtl/edo_chan_if.sv
rtl/edo_div.sv
rtl/edo_exp2.sv
rtl/edo_scale.sv
rtl/edo_note_to_frequency.sv
dv/testbench.sv
